@@ rtl/core/gb18030_four_byte_to_utf8_macros.svh @@
// Assertion macros used by the checker of the GB18030 to UTF-8 block.
`ifndef GB18030_FOUR_BYTE_TO_UTF8_MACROS_SVH
`define GB18030_FOUR_BYTE_TO_UTF8_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define GBF2U_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define GBF2U_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gbf2u_pkg.sv @@
`timescale 1ns / 1ps

package gbf2u_pkg;

    localparam int RANGE_COUNT = 13;
    localparam int IDX_W       = 4;
    localparam int IDX_DEPTH   = 2 ** IDX_W;
    localparam int LIN_W       = 22;
    localparam int WORD_W      = 32;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [LIN_W-1:0]  t_lin;
    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_range_tab [RANGE_COUNT];
    typedef t_word t_off_tab [IDX_DEPTH];

    typedef struct packed {
        logic hit;
        t_idx idx;
        t_lin lin;
    } t_match;

    localparam t_range_tab RANGE_FIRST_CP = '{
        32'h0000_0452, 32'h0000_2643, 32'h0000_361B, 32'h0000_3CE1,
        32'h0000_4160, 32'h0000_44D7, 32'h0000_478E, 32'h0000_49B8,
        32'h0000_9FA6, 32'h0000_E865, 32'h0000_FA2A, 32'h0000_FFE6,
        32'h0001_0000
    };

    localparam t_range_tab RANGE_LO = '{
        32'h8130_D330, 32'h8137_A839, 32'h8230_A633, 32'h8231_D438,
        32'h8232_C937, 32'h8233_A339, 32'h8233_E838, 32'h8234_A131,
        32'h8235_8F33, 32'h8336_D030, 32'h8430_9C38, 32'h8431_A234,
        32'h9030_8130
    };

    localparam t_range_tab RANGE_HI = '{
        32'h8136_A531, 32'h8138_FD38, 32'h8230_F237, 32'h8232_AF32,
        32'h8232_F837, 32'h8233_C931, 32'h8234_9638, 32'h8234_E733,
        32'h8336_C738, 32'h8430_8534, 32'h8431_8537, 32'h8431_A439,
        32'hE332_9A35
    };

    // Linear index in radix 126/10/126/10, without the common base offset.
    function automatic t_lin gbf2u_lin(input t_word v);
        t_lin a;
        t_lin b;
        t_lin c;
        t_lin d;
        a = t_lin'(v[31:24]);
        b = t_lin'(v[23:16]);
        c = t_lin'(v[15:8]);
        d = t_lin'(v[7:0]);
        return t_lin'(a * t_lin'(12600) + b * t_lin'(1260) + c * t_lin'(10) + d);
    endfunction

    // First code point minus the linear index of the range start, modulo 2^32.
    function automatic t_off_tab gbf2u_calc_off();
        t_off_tab tab;
        for (int k = 0; k < IDX_DEPTH; k++) begin
            if (k < RANGE_COUNT) begin
                tab[k] = RANGE_FIRST_CP[k] - t_word'(gbf2u_lin(RANGE_LO[k]));
            end else begin
                tab[k] = '0;
            end
        end
        return tab;
    endfunction

    localparam t_off_tab RANGE_OFF = gbf2u_calc_off();

endpackage

@@ rtl/core/gbf2u_ifs.sv @@
`timescale 1ns / 1ps

interface gbf2u_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] gb_code;

    modport source (output valid, output gb_code, input ready);
    modport sink   (input valid, input gb_code, output ready);
endinterface

interface gbf2u_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] utf8_word;
    logic        found;

    modport source (output valid, output utf8_word, output found, input ready);
    modport sink   (input valid, input utf8_word, input found, output ready);
endinterface

@@ rtl/core/gbf2u_match.sv @@
`timescale 1ns / 1ps

module gbf2u_match
    import gbf2u_pkg::*;
(
    input  t_word  i_code,
    output t_match o_match
);

    logic [RANGE_COUNT-1:0] in_range;

    always_comb begin
        for (int k = 0; k < RANGE_COUNT; k++) begin
            in_range[k] = (i_code >= RANGE_LO[k]) && (i_code <= RANGE_HI[k]);
        end
    end

    // Lowest range index wins.
    always_comb begin
        o_match.hit = 1'b0;
        o_match.idx = '0;
        for (int k = RANGE_COUNT - 1; k >= 0; k--) begin
            if (in_range[k]) begin
                o_match.hit = 1'b1;
                o_match.idx = t_idx'(k);
            end
        end
        o_match.lin = gbf2u_lin(i_code);
    end

endmodule

@@ rtl/core/gbf2u_enc.sv @@
`timescale 1ns / 1ps

module gbf2u_enc
    import gbf2u_pkg::*;
(
    input  t_match i_match,
    output t_word  o_word,
    output logic   o_found
);

    t_word cp;
    t_word utf;

    assign cp = t_word'(i_match.lin) + RANGE_OFF[i_match.idx];

    always_comb begin
        priority if (cp <= 32'h0000_007F) begin
            utf = cp;
        end else if (cp <= 32'h0000_07FF) begin
            utf = {16'h0000, 3'b110, cp[10:6], 2'b10, cp[5:0]};
        end else if (cp <= 32'h0000_FFFF) begin
            utf = {8'h00, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
        end else begin
            utf = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
        end
    end

    assign o_word  = i_match.hit ? utf : '0;
    assign o_found = i_match.hit;

endmodule

@@ rtl/core/gb18030_four_byte_to_utf8.sv @@
`timescale 1ns / 1ps

// Channel   Role    Payload                        Beat
// i_gb      sink    gb_code[31:0]                  valid & ready
// o_utf     source  utf8_word[31:0], found         valid & ready
//
// Three register stages: input, range match with linear index, encoded result.
// One beat per cycle while the output accepts; a code passes the input, match and result
// registers in that order. Input stalls only with all three stages full and output held.
// Stages advance independently, so bubbles close up while the output stalls.
// Synchronous active-low reset clears the stage valid flags only.

module gb18030_four_byte_to_utf8
    import gbf2u_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gbf2u_in_if.sink    i_gb,
    gbf2u_out_if.source o_utf
);

    logic   r_v1;
    logic   r_v2;
    logic   r_v3;
    t_word  r_code;
    t_match r_match;
    t_word  r_word;
    logic   r_found;

    t_match n_match;
    t_word  n_word;
    logic   n_found;

    logic ld1;
    logic ld2;
    logic ld3;

    assign ld3 = !r_v3 || o_utf.ready;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;

    gbf2u_match u_match (
        .i_code  (r_code),
        .o_match (n_match)
    );

    gbf2u_enc u_enc (
        .i_match (r_match),
        .o_word  (n_word),
        .o_found (n_found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_gb.valid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_code <= i_gb.gb_code;
        end
        if (ld2) begin
            r_match <= n_match;
        end
        if (ld3) begin
            r_word  <= n_word;
            r_found <= n_found;
        end
    end

    assign i_gb.ready      = ld1;
    assign o_utf.valid     = r_v3;
    assign o_utf.utf8_word = r_word;
    assign o_utf.found     = r_found;

endmodule

@@ rtl/core/gbf2u_chk.sv @@
`timescale 1ns / 1ps

`include "gb18030_four_byte_to_utf8_macros.svh"

module gbf2u_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_utf8_word,
    input logic        i_found
);

    `GBF2U_ASSERT_NOW(a_miss_zero,
        i_out_valid && !i_found,
        i_utf8_word == 32'h0,
        "unmapped result with nonzero word")
    `GBF2U_ASSERT_NOW(a_four_byte_form,
        i_out_valid && i_found && (i_utf8_word[31:24] != 8'h00),
        (i_utf8_word[31:27] == 5'b11110) && (i_utf8_word[23:22] == 2'b10)
            && (i_utf8_word[15:14] == 2'b10) && (i_utf8_word[7:6] == 2'b10),
        "malformed four-byte sequence")
    `GBF2U_ASSERT_NOW(a_ready_when_empty,
        !i_out_valid,
        i_in_ready,
        "input stalled with empty output")
    `GBF2U_ASSERT_NEXT(a_hold_stalled,
        i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_utf8_word) && $stable(i_found),
        "stalled result dropped or changed")

endmodule

bind gb18030_four_byte_to_utf8 gbf2u_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_gb.ready),
    .i_out_valid (o_utf.valid),
    .i_out_ready (o_utf.ready),
    .i_utf8_word (o_utf.utf8_word),
    .i_found     (o_utf.found)
);

@@ test/gbf2u_conversion_check.sv @@
`timescale 1ns / 1ps

module gbf2u_conversion_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_gb_valid,
    input  logic        i_gb_ready,
    input  logic [31:0] i_gb_code,
    input  logic        i_utf_valid,
    input  logic        i_utf_ready,
    input  logic [31:0] i_utf8_word,
    input  logic        i_found,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_compared,
    output int          o_mapped
);

    localparam int          SPAN_COUNT     = 13;
    localparam logic [31:0] LIN_W0         = 32'd12600;
    localparam logic [31:0] LIN_W1         = 32'd1260;
    localparam logic [31:0] LIN_W2         = 32'd10;
    localparam logic [31:0] ONE_BYTE_MAX   = 32'h0000_007F;
    localparam logic [31:0] TWO_BYTE_MAX   = 32'h0000_07FF;
    localparam logic [31:0] THREE_BYTE_MAX = 32'h0000_FFFF;

    localparam logic [31:0] SPAN_CP [SPAN_COUNT] = '{
        32'h0000_0452, 32'h0000_2643, 32'h0000_361B, 32'h0000_3CE1,
        32'h0000_4160, 32'h0000_44D7, 32'h0000_478E, 32'h0000_49B8,
        32'h0000_9FA6, 32'h0000_E865, 32'h0000_FA2A, 32'h0000_FFE6,
        32'h0001_0000
    };

    localparam logic [31:0] SPAN_LO [SPAN_COUNT] = '{
        32'h8130_D330, 32'h8137_A839, 32'h8230_A633, 32'h8231_D438,
        32'h8232_C937, 32'h8233_A339, 32'h8233_E838, 32'h8234_A131,
        32'h8235_8F33, 32'h8336_D030, 32'h8430_9C38, 32'h8431_A234,
        32'h9030_8130
    };

    localparam logic [31:0] SPAN_HI [SPAN_COUNT] = '{
        32'h8136_A531, 32'h8138_FD38, 32'h8230_F237, 32'h8232_AF32,
        32'h8232_F837, 32'h8233_C931, 32'h8234_9638, 32'h8234_E733,
        32'h8336_C738, 32'h8430_8534, 32'h8431_8537, 32'h8431_A439,
        32'hE332_9A35
    };

    typedef struct packed {
        logic [31:0] gb_code;
        logic [31:0] utf8_word;
        logic        found;
    } t_utf8_char;

    t_utf8_char utf8_due [$];

    function automatic logic [31:0] lin_of_code(input logic [31:0] v);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        a = {24'd0, v[31:24]};
        b = {24'd0, v[23:16]};
        c = {24'd0, v[15:8]};
        d = {24'd0, v[7:0]};
        return a * LIN_W0 + b * LIN_W1 + c * LIN_W2 + d;
    endfunction

    function automatic t_utf8_char utf8_of_gb(input logic [31:0] code);
        t_utf8_char  ch;
        logic [31:0] cp;
        ch.gb_code   = code;
        ch.utf8_word = '0;
        ch.found     = 1'b0;
        for (int k = 0; k < SPAN_COUNT; k++) begin
            if (!ch.found && code >= SPAN_LO[k] && code <= SPAN_HI[k]) begin
                cp       = lin_of_code(code) - lin_of_code(SPAN_LO[k]) + SPAN_CP[k];
                ch.found = 1'b1;
                if (cp <= ONE_BYTE_MAX) begin
                    ch.utf8_word = cp;
                end else if (cp <= TWO_BYTE_MAX) begin
                    ch.utf8_word = {16'd0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
                end else if (cp <= THREE_BYTE_MAX) begin
                    ch.utf8_word = {8'd0, 4'b1110, cp[15:12], 2'b10, cp[11:6],
                                    2'b10, cp[5:0]};
                end else begin
                    ch.utf8_word = {5'b11110, cp[20:18], 2'b10, cp[17:12],
                                    2'b10, cp[11:6], 2'b10, cp[5:0]};
                end
            end
        end
        return ch;
    endfunction

    always @(posedge i_clk) begin : conv_compare
        t_utf8_char want;
        if (i_rst_n) begin
            if (i_gb_valid && i_gb_ready) begin
                utf8_due.push_back(utf8_of_gb(i_gb_code));
            end
            if (i_utf_valid && i_utf_ready) begin
                if (utf8_due.size() == 0) begin
                    $display("%0t: unexpected result beat: expected none, actual word %h found %b",
                             $time, i_utf8_word, i_found);
                    o_fail_count++;
                end else begin
                    want = utf8_due.pop_front();
                    o_compared++;
                    if (want.found) begin
                        o_mapped++;
                    end
                    if (i_utf8_word !== want.utf8_word) begin
                        $display("%0t: code %h utf8_word: expected %h, actual %h",
                                 $time, want.gb_code, want.utf8_word, i_utf8_word);
                        o_fail_count++;
                    end
                    if (i_found !== want.found) begin
                        $display("%0t: code %h found: expected %b, actual %b",
                                 $time, want.gb_code, want.found, i_found);
                        o_fail_count++;
                    end
                end
            end
            o_pending = utf8_due.size();
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_CODES  = 1100;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT       = 350;
    localparam int DRAIN_AT      = 750;
    localparam int DRAIN_CYCLES  = 8;
    localparam int WATCHDOG_IDLE = 2000;

    logic i_clk;
    logic i_rst_n;

    gbf2u_in_if  gb_if ();
    gbf2u_out_if utf_if ();

    int fail_count;
    int pending;
    int compared;
    int mapped;
    int sent;
    int idle_run;
    bit hold_out;

    gb18030_four_byte_to_utf8 u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gb    (gb_if),
        .o_utf   (utf_if)
    );

    gbf2u_conversion_check u_conv_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gb_valid   (gb_if.valid),
        .i_gb_ready   (gb_if.ready),
        .i_gb_code    (gb_if.gb_code),
        .i_utf_valid  (utf_if.valid),
        .i_utf_ready  (utf_if.ready),
        .i_utf8_word  (utf_if.utf8_word),
        .i_found      (utf_if.found),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared),
        .o_mapped     (mapped)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    task automatic push_code(input logic [31:0] code);
        int len;
        len = (((sent / 128) % 4) == 2) ? 0 : idle_len();
        repeat (len) begin
            @(negedge i_clk);
            gb_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        gb_if.valid   <= 1'b1;
        gb_if.gb_code <= code;
        do @(posedge i_clk); while (!gb_if.ready);
        sent++;
    endtask

    // Output side: random back-pressure, steady stretches, one long hold.
    initial begin
        int len;
        utf_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_out) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    utf_if.ready <= 1'b0;
                end
                hold_out = 1'b0;
            end else begin
                len = (((sent / 150) % 4) == 3) ? 0 : idle_len();
                repeat (len) begin
                    @(negedge i_clk);
                    utf_if.ready <= 1'b0;
                end
                @(negedge i_clk);
                utf_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((gb_if.valid && gb_if.ready) || (utf_if.valid && utf_if.ready)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= WATCHDOG_IDLE) begin
            $display("%0t: no beat for %0d cycles", $time, idle_run);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [31:0] corner_codes [12] = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h8130_D32F, 32'h8136_A531,
            32'h8136_A532, 32'h8336_C738, 32'hE332_9A36, 32'h8131_0000,
            32'h830A_D633, 32'h830A_D6B2, 32'h830A_D6B3, 32'hE300_0000
        };
        logic [31:0] code;
        logic [31:0] lo;
        logic [31:0] hi;
        int          k;

        i_rst_n       = 1'b0;
        gb_if.valid   = 1'b0;
        gb_if.gb_code = '0;
        hold_out      = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < gbf2u_pkg::RANGE_COUNT; r++) begin
            push_code(gbf2u_pkg::RANGE_LO[r]);
        end
        foreach (corner_codes[i]) begin
            push_code(corner_codes[i]);
        end

        for (int n = 0; n < RANDOM_CODES; n++) begin
            if (n == HOLD_AT) begin
                hold_out = 1'b1;
            end
            if (n == DRAIN_AT) begin
                @(negedge i_clk);
                gb_if.valid <= 1'b0;
                wait (pending == 0);
            end
            k  = $urandom_range(0, gbf2u_pkg::RANGE_COUNT - 1);
            lo = gbf2u_pkg::RANGE_LO[k];
            hi = gbf2u_pkg::RANGE_HI[k];
            case ($urandom_range(0, 9))
                0: code = lo;
                1: code = hi;
                2: code = lo - 32'd1;
                3: code = hi + 32'd1;
                4, 5: code = $urandom_range(hi, lo);
                6, 7, 8: begin
                    code[31:24] = $urandom_range(0, 1) ? 8'($urandom_range(8'h81, 8'h84))
                                                       : 8'($urandom_range(8'h90, 8'hE3));
                    code[23:16] = 8'($urandom_range(8'h30, 8'h39));
                    code[15:8]  = 8'($urandom_range(8'h81, 8'hFE));
                    code[7:0]   = 8'($urandom_range(8'h30, 8'h39));
                end
                default: code = $urandom;
            endcase
            push_code(code);
        end

        @(negedge i_clk);
        gb_if.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d codes: range bounds and gaps, bad bytes, long output hold, drain pause",
                 sent);
        $display("%0d results compared, %0d in a mapped range, %0d mismatches",
                 compared, mapped, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/gbf2u_pkg.sv
rtl/core/gbf2u_ifs.sv
rtl/core/gbf2u_match.sv
rtl/core/gbf2u_enc.sv
rtl/core/gb18030_four_byte_to_utf8.sv
rtl/core/gbf2u_chk.sv
test/gbf2u_conversion_check.sv
test/testbench.sv
